// ===== sv/bth_pkg.sv =====
// ----------------------------------------------------------------------------
// bth_pkg
// Shared types, constants and the object length table for the BTHome
// temperature parser.
// ----------------------------------------------------------------------------
package bth_pkg;

    localparam int PAYLOAD_BYTES_MAX_DEF = 255;

    localparam int TEMP_W = 20;

    localparam logic [7:0]  AD_TYPE_SVC16  = 8'h16;
    localparam logic [15:0] UUID_RESET     = 16'hFCD2;
    localparam logic [7:0]  OBJ_TEMP_CENTI = 8'h02;
    localparam logic [7:0]  OBJ_TEMP_DECI  = 8'h45;

    // parser state carried from byte to byte
    typedef struct packed {
        logic [7:0]               field_remaining;
        logic [7:0]               field_type;
        logic [7:0]               field_offset;
        logic [7:0]               uuid_low_byte;
        logic                     in_service_field;
        logic                     walk_stopped;
        logic [7:0]               object_id;
        logic [2:0]               object_bytes_left;
        logic [15:0]              object_value;
        logic signed [TEMP_W-1:0] pending_temperature;
        logic                     pending_valid;
        logic                     final_found;
        logic                     final_valid;
        logic signed [TEMP_W-1:0] final_temperature;
    } t_state;

    // number of data bytes that follow an object id
    function automatic logic [2:0] obj_data_len(input logic [7:0] id);
        logic [2:0] len;
        case (id) inside
            [8'h0F:8'h2D]:
                len = 3'd1;
            8'h02, 8'h03, 8'h06, 8'h07, 8'h08, 8'h0C, 8'h0D, 8'h0E, 8'h2F,
            8'h3D, 8'h40, 8'h41, 8'h43, 8'h44, 8'h45, 8'h46, 8'h48, 8'h49,
            8'h4A, 8'h4F, 8'h51, 8'h52:
                len = 3'd2;
            8'h04, 8'h05, 8'h0A, 8'h0B, 8'h42, 8'h4B:
                len = 3'd3;
            8'h3E, 8'h47, 8'h4C, 8'h4D, 8'h4E, 8'h50:
                len = 3'd4;
            default:
                len = 3'd1;
        endcase
        return len;
    endfunction

endpackage

// ===== sv/bth_intf.sv =====
// ----------------------------------------------------------------------------
// bth channel interfaces
// Valid/ready channels for payload bytes, parse results and the UUID
// register write.
// ----------------------------------------------------------------------------
interface bth_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       last_byte;

    modport source (output valid, output payload_byte, output last_byte, input ready);
    modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface

interface bth_out_if;
    logic                              valid;
    logic                              ready;
    logic                              service_found;
    logic                              temperature_valid;
    logic signed [bth_pkg::TEMP_W-1:0] temperature_centi;

    modport source (output valid, output service_found, output temperature_valid,
                    output temperature_centi, input ready);
    modport sink   (input valid, input service_found, input temperature_valid,
                    input temperature_centi, output ready);
endinterface

interface bth_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] service_uuid;

    modport source (output valid, output service_uuid, input ready);
    modport sink   (input valid, input service_uuid, output ready);
endinterface

// ===== sv/bth_step.sv =====
// ----------------------------------------------------------------------------
// bth_step
// One parser step: next state of the AD structure walk and the BTHome
// object decoder for one payload byte.
// ----------------------------------------------------------------------------
module bth_step (
    input  bth_pkg::t_state i_state,
    input  logic [7:0]      i_byte,
    input  logic [15:0]     i_uuid,
    input  logic            i_walk_en,
    output bth_pkg::t_state o_state
);

    bth_pkg::t_state n_s;
    logic [15:0]                       n_value;
    logic signed [bth_pkg::TEMP_W-1:0] raw_ext;
    logic signed [bth_pkg::TEMP_W-1:0] raw_x10;

    // next object value and both temperature scalings
    assign n_value = {i_byte, i_state.object_value[15:8]};
    assign raw_ext = bth_pkg::TEMP_W'($signed(n_value));
    assign raw_x10 = (raw_ext <<< 3) + (raw_ext <<< 1);

    always_comb begin
        n_s = i_state;
        if (i_walk_en) begin
            if (i_state.field_remaining == 8'd0) begin
                if (i_byte == 8'd0) begin
                    n_s.walk_stopped = 1'b1;
                end else begin
                    n_s.field_remaining  = i_byte;
                    n_s.field_offset     = 8'd0;
                    n_s.in_service_field = 1'b0;
                end
            end else begin
                if (i_state.field_offset == 8'd0) begin
                    n_s.field_type = i_byte;
                end else if (i_state.field_offset == 8'd1) begin
                    n_s.uuid_low_byte = i_byte;
                end else if (i_state.field_offset == 8'd2) begin
                    if (i_state.field_type == bth_pkg::AD_TYPE_SVC16 &&
                        i_state.field_remaining >= 8'd2 &&
                        {i_byte, i_state.uuid_low_byte} == i_uuid) begin
                        n_s.in_service_field    = 1'b1;
                        n_s.object_bytes_left   = 3'd0;
                        n_s.object_id           = 8'd0;
                        n_s.object_value        = 16'd0;
                        n_s.pending_valid       = 1'b0;
                        n_s.pending_temperature = '0;
                    end
                end else if (i_state.field_offset >= 8'd4 && i_state.in_service_field) begin
                    // byte offset three is the device-info byte
                    if (i_state.object_bytes_left == 3'd0) begin
                        n_s.object_id         = i_byte;
                        n_s.object_bytes_left = bth_pkg::obj_data_len(i_byte);
                        n_s.object_value      = 16'd0;
                    end else begin
                        n_s.object_value      = n_value;
                        n_s.object_bytes_left = i_state.object_bytes_left - 3'd1;
                        if (i_state.object_bytes_left == 3'd1) begin
                            if (i_state.object_id == bth_pkg::OBJ_TEMP_CENTI) begin
                                n_s.pending_temperature = raw_ext;
                                n_s.pending_valid       = 1'b1;
                            end else if (i_state.object_id == bth_pkg::OBJ_TEMP_DECI) begin
                                n_s.pending_temperature = raw_x10;
                                n_s.pending_valid       = 1'b1;
                            end
                        end
                    end
                end
                n_s.field_offset    = i_state.field_offset + 8'd1;
                n_s.field_remaining = i_state.field_remaining - 8'd1;
                // matching field complete: latch the result and stop walking
                if (i_state.field_remaining == 8'd1 && n_s.in_service_field) begin
                    n_s.final_found       = 1'b1;
                    n_s.final_valid       = n_s.pending_valid;
                    n_s.final_temperature = n_s.pending_valid ? n_s.pending_temperature : '0;
                    n_s.walk_stopped      = 1'b1;
                end
            end
        end
    end

    assign o_state = n_s;

endmodule

// ===== sv/ble_adv_bthome_temperature_parser.sv =====
// ----------------------------------------------------------------------------
// ble_adv_bthome_temperature_parser
// BLE advertising payload parser that extracts a BTHome v2 temperature.
// ----------------------------------------------------------------------------
// Takes one payload byte per transfer and can take a byte in every cycle unless
// a waiting result is not taken; the parse step for a byte is done in the cycle
// it is accepted. On the byte flagged as last, one result (service found,
// temperature valid, temperature in hundredths of a degree) is loaded into the
// output register, which drives the output channel; the parser state is then
// cleared for the next payload. While a result waits to be taken, a new byte
// is still accepted in the same cycle that the result transfer completes.
// Bytes beyond PAYLOAD_BYTES_MAX in one payload are ignored except for their
// last-byte flag. The service UUID register (reset 0xFCD2) is always ready and
// should only be written between payloads.
module ble_adv_bthome_temperature_parser #(
    parameter int PAYLOAD_BYTES_MAX = bth_pkg::PAYLOAD_BYTES_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bth_in_if.sink     i_in,
    bth_out_if.source  o_out,
    bth_cfg_if.sink    i_cfg
);

    localparam int CNT_W = $clog2(PAYLOAD_BYTES_MAX + 1);

    bth_pkg::t_state r_state;
    bth_pkg::t_state n_state;
    bth_pkg::t_state step_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [15:0]      r_uuid;
    logic             r_out_valid;
    logic             r_out_found;
    logic             r_out_tvalid;
    logic signed [bth_pkg::TEMP_W-1:0] r_out_temp;

    logic in_xfer;
    logic walk_en;
    logic cnt_open;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_xfer     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign cnt_open = r_cnt < CNT_W'(PAYLOAD_BYTES_MAX);
    assign walk_en  = cnt_open && !r_state.walk_stopped;

    bth_step u_step (
        .i_state   (r_state),
        .i_byte    (i_in.payload_byte),
        .i_uuid    (r_uuid),
        .i_walk_en (walk_en),
        .o_state   (step_state)
    );

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        if (in_xfer) begin
            if (i_in.last_byte) begin
                n_state = '0;
                n_cnt   = '0;
            end else begin
                n_state = step_state;
                n_cnt   = cnt_open ? r_cnt + CNT_W'(1) : r_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_cnt       <= '0;
            r_uuid      <= bth_pkg::UUID_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg.valid) begin
                r_uuid <= i_cfg.service_uuid;
            end
            if (in_xfer && i_in.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded on the last byte
    always_ff @(posedge i_clk) begin
        if (in_xfer && i_in.last_byte) begin
            r_out_found  <= step_state.final_found;
            r_out_tvalid <= step_state.final_found && step_state.final_valid;
            r_out_temp   <= (step_state.final_found && step_state.final_valid) ?
                            step_state.final_temperature : '0;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.service_found     = r_out_found;
    assign o_out.temperature_valid = r_out_tvalid;
    assign o_out.temperature_centi = r_out_temp;

`ifndef SYNTHESIS
    a_result_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in.last_byte |=> r_out_valid)
        else $error("no result after last byte");

    a_no_result_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && !i_in.last_byte |=> !r_out_valid)
        else $error("result without last byte");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in.last_byte |=> r_cnt == '0 && !r_state.walk_stopped &&
        !r_state.final_found)
        else $error("parser state not cleared after last byte");

    a_temp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_tvalid |-> r_out_temp == '0)
        else $error("temperature nonzero without valid flag");
`endif

endmodule
